// ===== hdl/swtm_pkg.sv =====
// Package for the sliding-window trimmed mean core.
// Holds sizes, the sequencer state type and the config register indexes.
package swtm_pkg;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int AW          = $clog2(MAX_WINDOW);
  localparam int CW          = AW + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + AW;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 7;
  localparam int TRIM_BITS   = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIM   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DROP_RD, ST_DROP_FIND, ST_DROP_SHIFT, ST_INS_RD, ST_INS_SHIFT,
    ST_SUM_RD, ST_SUM_ACC, ST_DIV, ST_OUT
  } state_t;
endpackage

// ===== hdl/swtm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module swtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/sliding_window_trimmed_mean_core.sv =====
// Sliding-window trimmed mean core: top level.
// Uses swtm_pkg and two swtm_ram instances (arrival ring, sorted store).
//
// Usage: samples arrive on sample/sample_valid/sample_ready, results leave on
// full_res/bad_config/mean with res_valid/res_ready. One result per sample.
// Config: cfg_we/cfg_index/cfg_data. The user must see that config is
// written only while idle; the block itself does not enforce this.
// One item at a time. Processing walks the sorted store, one memory access
// per cycle: removing the oldest sample searches, then shifts down;
// insertion compares and shifts up; the middle sum reads the kept entries;
// then a restoring divide gives one quotient bit a cycle. A shrunk window
// adds an extra drop walk for each surplus sample. A result sits in an
// output register; while the receiver stalls, no new sample is taken.
// The next sample is taken the cycle after the result transfer. Reset sets
// config to window 64 and trim 1, and clears fill count, ring pointer and
// the sequencer; memory contents are not cleared since only written entries
// are read.
module sliding_window_trimmed_mean_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [swtm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [swtm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic [swtm_pkg::SAMPLE_BITS-1:0]     sample,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 full_res,
  output logic                                 bad_config,
  output logic [swtm_pkg::SAMPLE_BITS-1:0]     mean
);
  localparam int AW = swtm_pkg::AW;
  localparam int CW = swtm_pkg::CW;
  localparam int SB = swtm_pkg::SAMPLE_BITS;
  localparam int SUMB = swtm_pkg::SUM_BITS;

  swtm_pkg::state_t state, state_next;

  logic [6:0] window_size;
  logic [swtm_pkg::TRIM_BITS-1:0] trim_count;
  logic [CW-1:0] fill_count;
  logic [AW-1:0] oldest_pointer;
  logic [SB-1:0] cur;
  logic [CW-1:0] idx;
  logic [SUMB-1:0] acc;
  logic [CW-1:0] divisor;
  logic [SUMB-1:0] quo;
  logic [CW-1:0] rem;
  logic [4:0] bitc;
  logic bad;

  logic [CW-1:0] w_eff;
  logic [CW:0] two_t;
  always_comb begin
    if ({1'b0, window_size} > 8'(swtm_pkg::MAX_WINDOW)) w_eff = CW'(swtm_pkg::MAX_WINDOW);
    else if (window_size == '0) w_eff = CW'(1);
    else w_eff = CW'(window_size);
    two_t = (CW+1)'({trim_count, 1'b0});
  end

  // memories
  logic          ring_we, srt_we;
  logic [AW-1:0] ring_wa, ring_ra, srt_wa, srt_ra;
  logic [SB-1:0] ring_wd, ring_rd, srt_wd, srt_rd;

  swtm_ram #(.WIDTH(SB), .DEPTH(swtm_pkg::MAX_WINDOW)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
    .raddr(ring_ra), .rdata(ring_rd));
  swtm_ram #(.WIDTH(SB), .DEPTH(swtm_pkg::MAX_WINDOW)) u_sorted (
    .clk(clk), .we(srt_we), .waddr(srt_wa), .wdata(srt_wd),
    .raddr(srt_ra), .rdata(srt_rd));

  // restoring divide step
  logic [CW:0] rem_sh;
  assign rem_sh = {rem, quo[SUMB-1]};

  assign sample_ready = (state == swtm_pkg::ST_IDLE) && !res_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      swtm_pkg::ST_IDLE:
        if (sample_valid && sample_ready) begin
          if (fill_count != '0 && fill_count >= w_eff) state_next = swtm_pkg::ST_DROP_RD;
          else state_next = swtm_pkg::ST_INS_RD;
        end
      swtm_pkg::ST_DROP_RD:   state_next = swtm_pkg::ST_DROP_FIND;
      swtm_pkg::ST_DROP_FIND:
        if (srt_rd == ring_rd || idx + CW'(1) >= fill_count)
          state_next = swtm_pkg::ST_DROP_SHIFT;
      swtm_pkg::ST_DROP_SHIFT:
        if (idx + CW'(1) >= fill_count) begin
          if (fill_count - CW'(1) >= w_eff && fill_count != CW'(1))
            state_next = swtm_pkg::ST_DROP_RD;
          else state_next = swtm_pkg::ST_INS_RD;
        end
      swtm_pkg::ST_INS_RD:    state_next = swtm_pkg::ST_INS_SHIFT;
      swtm_pkg::ST_INS_SHIFT:
        if (idx == '0 || srt_rd <= cur) begin
          if (!bad && fill_count + CW'(1) == w_eff) state_next = swtm_pkg::ST_SUM_RD;
          else state_next = swtm_pkg::ST_OUT;
        end
      swtm_pkg::ST_SUM_RD:    state_next = swtm_pkg::ST_SUM_ACC;
      swtm_pkg::ST_SUM_ACC:
        if ((CW+1)'(idx) + (CW+1)'(trim_count) + (CW+1)'(1) >= (CW+1)'(w_eff))
          state_next = swtm_pkg::ST_DIV;
      swtm_pkg::ST_DIV:
        if (bitc == 5'(SUMB - 1)) state_next = swtm_pkg::ST_OUT;
      swtm_pkg::ST_OUT:       state_next = swtm_pkg::ST_IDLE;
      default:                state_next = swtm_pkg::ST_IDLE;
    endcase
  end

  // memory controls: drop walks read idx, shift writes idx-1;
  // insert walks read idx-1, shift writes idx.
  always_comb begin
    ring_we = 1'b0;
    ring_wa = AW'(oldest_pointer + AW'(fill_count));
    ring_wd = cur;
    ring_ra = oldest_pointer;
    srt_we  = 1'b0;
    srt_wa  = idx[AW-1:0];
    srt_wd  = srt_rd;
    srt_ra  = idx[AW-1:0];
    unique case (state)
      swtm_pkg::ST_DROP_RD: begin
        srt_ra = '0;
      end
      swtm_pkg::ST_DROP_FIND: begin
        srt_ra = AW'(idx + CW'(1));
      end
      swtm_pkg::ST_DROP_SHIFT: begin
        srt_we = idx != '0;
        srt_wa = AW'(idx - CW'(1));
        srt_ra = AW'(idx + CW'(1));
      end
      swtm_pkg::ST_INS_RD: begin
        ring_we = 1'b1;
        srt_ra  = AW'(idx - CW'(1));
      end
      swtm_pkg::ST_INS_SHIFT: begin
        srt_we = 1'b1;
        srt_wa = idx[AW-1:0];
        if (idx != '0 && srt_rd > cur) srt_wd = srt_rd;
        else srt_wd = cur;
        srt_ra = AW'(idx - CW'(2));
      end
      swtm_pkg::ST_SUM_RD, swtm_pkg::ST_SUM_ACC: begin
        srt_ra = AW'(idx + CW'(state == swtm_pkg::ST_SUM_ACC));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= swtm_pkg::ST_IDLE;
      window_size    <= 7'd64;
      trim_count     <= 5'd1;
      fill_count     <= '0;
      oldest_pointer <= '0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == swtm_pkg::REG_WINDOW) window_size <= cfg_data;
      if (cfg_we && cfg_index == swtm_pkg::REG_TRIM)
        trim_count <= cfg_data[swtm_pkg::TRIM_BITS-1:0];
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        swtm_pkg::ST_IDLE:
          if (sample_valid && sample_ready) begin
            cur <= sample;
            bad <= {1'b0, two_t} >= (CW+2)'(w_eff);
            idx <= fill_count;
          end
        swtm_pkg::ST_DROP_RD: idx <= '0;
        swtm_pkg::ST_DROP_FIND: idx <= idx + CW'(1);
        swtm_pkg::ST_DROP_SHIFT: begin
          if (idx + CW'(1) >= fill_count) begin
            fill_count     <= fill_count - CW'(1);
            oldest_pointer <= oldest_pointer + AW'(1);
            idx            <= fill_count - CW'(1);
          end else begin
            idx <= idx + CW'(1);
          end
        end
        swtm_pkg::ST_INS_RD: ;
        swtm_pkg::ST_INS_SHIFT: begin
          if (idx == '0 || srt_rd <= cur) begin
            fill_count <= fill_count + CW'(1);
            idx        <= CW'(trim_count);
            acc        <= '0;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        swtm_pkg::ST_SUM_RD: ;
        swtm_pkg::ST_SUM_ACC: begin
          acc <= acc + SUMB'(srt_rd);
          idx <= idx + CW'(1);
          if ((CW+1)'(idx) + (CW+1)'(trim_count) + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
            quo     <= acc + SUMB'(srt_rd);
            rem     <= '0;
            bitc    <= '0;
            divisor <= CW'((CW+1)'(w_eff) - two_t);
          end
        end
        swtm_pkg::ST_DIV: begin
          bitc <= bitc + 5'(1);
          if (rem_sh >= {1'b0, divisor}) begin
            rem <= CW'(rem_sh - {1'b0, divisor});
            quo <= {quo[SUMB-2:0], 1'b1};
          end else begin
            rem <= rem_sh[CW-1:0];
            quo <= {quo[SUMB-2:0], 1'b0};
          end
        end
        swtm_pkg::ST_OUT: res_valid <= 1'b1;
        default: ;
      endcase
      if (state == swtm_pkg::ST_INS_SHIFT && (idx == '0 || srt_rd <= cur)) begin
        full_res   <= !bad && fill_count + CW'(1) == w_eff;
        bad_config <= bad;
        mean       <= '0;
      end
      if (state == swtm_pkg::ST_DIV && bitc == 5'(SUMB - 1)) begin
        mean <= (rem_sh >= {1'b0, divisor}) ? SB'({quo[SUMB-2:0], 1'b1})
                                            : SB'({quo[SUMB-2:0], 1'b0});
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench for sliding_window_trimmed_mean_core: random and directed samples
// checked against an in-bench trimmed-mean predictor. Depends on swtm_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic full_res;
    logic bad_config;
    logic [swtm_pkg::SAMPLE_BITS-1:0] mean;
  } trim_res_t;

  int err_count = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  class trim_scoreboard;
    int win_cfg = 64;
    int trim_cfg = 1;
    logic [swtm_pkg::SAMPLE_BITS-1:0] ring[$];
    trim_res_t pending[$];

    function void note_sample(logic [swtm_pkg::SAMPLE_BITS-1:0] s);
      int w, t, n, sum, k;
      logic [swtm_pkg::SAMPLE_BITS-1:0] srt[$];
      trim_res_t r;
      w = win_cfg > swtm_pkg::MAX_WINDOW ? swtm_pkg::MAX_WINDOW
                                         : (win_cfg == 0 ? 1 : win_cfg);
      t = trim_cfg;
      while (ring.size() > 0 && ring.size() >= w) void'(ring.pop_front());
      ring.push_back(s);
      r = '0;
      r.bad_config = (2 * t >= w);
      if (!r.bad_config && ring.size() == w) begin
        srt = ring;
        srt.sort();
        sum = 0;
        for (k = t; k + t < w; k++) sum += srt[k];
        n = w - 2 * t;
        r.mean = swtm_pkg::SAMPLE_BITS'(sum / n);
        r.full_res = 1'b1;
      end
      pending.push_back(r);
    endfunction

    task check_result(trim_res_t got);
      trim_res_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.full_res !== e.full_res)
        report($sformatf("full_res %b exp %b", got.full_res, e.full_res));
      if (got.bad_config !== e.bad_config)
        report($sformatf("bad_config %b exp %b", got.bad_config, e.bad_config));
      if (got.mean !== e.mean)
        report($sformatf("mean %0d exp %0d", got.mean, e.mean));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [swtm_pkg::CFG_IDX_BITS-1:0] cfg_index = swtm_pkg::REG_WINDOW;
  logic [swtm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic sample_valid = 0, sample_ready;
  logic [swtm_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic res_valid, res_ready = 0, full_res, bad_config;
  logic [swtm_pkg::SAMPLE_BITS-1:0] mean;

  int send_idle = 0, recv_stall = 0;
  bit rx_hold = 0;
  int mode = 0;  // 0 random sizes, 1 small, 2 low half, 3 random one-hot
  trim_scoreboard sb = new();

  sliding_window_trimmed_mean_core uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (rx_hold) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall);
    end
    if (!rst && res_valid && res_ready)
      sb.check_result('{full_res, bad_config, mean});
  end

  task automatic send_sample(input logic [swtm_pkg::SAMPLE_BITS-1:0] s);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(s);
  endtask

  task automatic write_cfg(input logic [swtm_pkg::CFG_IDX_BITS-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= swtm_pkg::CFG_DATA_BITS'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swtm_pkg::REG_WINDOW) sb.win_cfg = val & 7'h7f;
    else sb.trim_cfg = val & 5'h1f;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [swtm_pkg::SAMPLE_BITS-1:0] pick_sample();
    case (mode)
      1: return swtm_pkg::SAMPLE_BITS'($urandom_range(7));
      2: return swtm_pkg::SAMPLE_BITS'($urandom_range(16'h7fff));
      3: return swtm_pkg::SAMPLE_BITS'(16'h1 << $urandom_range(15));
      default: return swtm_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int ph, k, w, t;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: defaults, extremes, duplicates, shrink while full, bad trim
    send_sample(16'h0000);
    send_sample(16'hffff);
    drain();
    write_cfg(swtm_pkg::REG_WINDOW, 3);
    write_cfg(swtm_pkg::REG_TRIM, 0);
    send_sample(16'hffff); send_sample(16'hffff); send_sample(16'hffff);
    send_sample(16'h0000); send_sample(16'h5555); send_sample(16'haaaa);
    drain();
    write_cfg(swtm_pkg::REG_WINDOW, 5);
    write_cfg(swtm_pkg::REG_TRIM, 2);
    for (k = 0; k < 6; k++) send_sample(16'h1234);
    drain();
    write_cfg(swtm_pkg::REG_TRIM, 31);
    write_cfg(swtm_pkg::REG_WINDOW, 127);
    send_sample(16'h0001);
    drain();
    write_cfg(swtm_pkg::REG_WINDOW, 0);
    write_cfg(swtm_pkg::REG_TRIM, 0);
    send_sample(16'h8000); send_sample(16'h7fff);
    drain();
    write_cfg(swtm_pkg::REG_WINDOW, 4);
    write_cfg(swtm_pkg::REG_TRIM, 1);
    send_sample(16'h0003); send_sample(16'hfffe); send_sample(16'h0003);
    drain();
    // random phases over settings and idling profiles
    for (ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 82; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 82; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      case (ph)
        0: begin w = 64; t = 31; end
        1: begin w = 64; t = 0; end
        2: begin w = 3; t = 1; end
        3: begin w = 100; t = 20; end
        4: begin w = 3; t = 0; end
        default: begin w = $urandom_range(3, 20); t = $urandom_range(0, w / 2); end
      endcase
      write_cfg(swtm_pkg::REG_WINDOW, w);
      write_cfg(swtm_pkg::REG_TRIM, t);
      mode = ph % 4;
      if (ph == 5) begin
        send_idle = 0;
        fork
          begin
            @(posedge clk);
            rx_hold = 1'b1;
            repeat (3000) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (k = 0; k < 100; k++) send_sample(pick_sample());
      drain();
    end
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
